// File: src/rcm64_pkg.sv
// rcm64_pkg: shared constants for the 64-bit rsa crt exponentiation block
// no dependencies

package rcm64_pkg;

	localparam int W = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRIME_P      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_P        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_Q        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CRT_COEFF    = 3'd7;

	// modmul sequencer states
	localparam logic [1:0] MM_IDLE = 2'd0;
	localparam logic [1:0] MM_RUN  = 2'd1;

	typedef struct packed {
		logic start;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic done;
		logic [W-1:0] prod;
	} mm_rsp_t;

endpackage

// File: src/rsa_crt_modexp_64.sv
// rsa_crt_modexp_64: top level, control sequencer for encrypt and crt decrypt
// depends on rcm64_pkg and rcm64_modmul

// One 64-bit message item in, one result item out. Every modular product
// runs on one shared bit-serial modular multiplier (one multiplier bit per
// cycle). Operands are first reduced by a bit-serial remainder loop. For a
// nonzero modulus an exponentiation scans all 64 exponent bits, with a
// square, a conditional multiply and a step state per bit.
// Encrypt is one exponentiation; decrypt is two plus a subtract, one modular
// product and one 64-bit product done by shift-add; with p zero the subtract
// and the modular product are skipped. A message above the modulus skips the
// arithmetic and finishes with value zero and too_large set. The result
// register frees the input side once the result is loaded; the next item
// starts while the result still waits.
// Configuration is written through the cfg channel, index per register.

module rsa_crt_modexp_64 import rcm64_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [W-1:0]         message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [W-1:0]         value,
	output logic                 too_large
);

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_POW_SET = 5'd1;  // pick modulus, exponent for this pass
	localparam logic [4:0] S_RED     = 5'd2;  // x mod m, bit serial (base, m2 or coeff)
	localparam logic [4:0] S_SQ      = 5'd3;
	localparam logic [4:0] S_SQ_W    = 5'd4;
	localparam logic [4:0] S_MUL     = 5'd5;
	localparam logic [4:0] S_MUL_W   = 5'd6;
	localparam logic [4:0] S_POW_END = 5'd7;
	localparam logic [4:0] S_RED_B   = 5'd8;  // m2 mod p
	localparam logic [4:0] S_RED_C   = 5'd9;  // coeff mod p
	localparam logic [4:0] S_DIFF    = 5'd10;
	localparam logic [4:0] S_H       = 5'd11;
	localparam logic [4:0] S_H_W     = 5'd12;
	localparam logic [4:0] S_RECOMB  = 5'd13; // h * q, shift-add, wraps
	localparam logic [4:0] S_DONE    = 5'd14;
	localparam logic [4:0] S_OUT     = 5'd15;

	// configuration registers
	logic         dec_q;
	logic [W-1:0] mod_q, pub_q, p_q, q_q, ep_q, eq_q, coef_q;

	logic [4:0]   st_q;
	logic [W-1:0] msg_q;
	logic         pass_q;          // 0: first exponentiation, 1: second (mod q)
	logic [W-1:0] m_q, e_q;        // modulus and exponent of the current pass
	logic [W-1:0] base_q, acc_q;
	logic [6:0]   cnt_q;
	logic [W-1:0] m1_q, m2_q, t_q;
	logic [1:0]   red_sel_q;

	// bit-serial remainder: rem_q = (rem_q*2 + next bit) mod m
	logic [W-1:0] rem_q, rsh_q;
	logic [W:0]   rdbl, rdbl_red;

	// result register
	logic         ov_q;
	logic [W-1:0] val_q;
	logic         tl_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	rcm64_modmul u_mm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.rsp   (mm_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = ov_q;
	assign value     = val_q;
	assign too_large = tl_q;

	always_comb begin
		rdbl = {rem_q, rsh_q[W-1]};
		rdbl_red = (rdbl >= {1'b0, m_q}) ? rdbl - {1'b0, m_q} : rdbl;
	end

	always_comb begin
		mm_req.start = (st_q == S_SQ) || (st_q == S_MUL) || (st_q == S_H);
		mm_req.a = (st_q == S_MUL) ? base_q : (st_q == S_H) ? t_q : acc_q;
		mm_req.b = (st_q == S_H) ? m1_q : acc_q;
		mm_req.m = m_q;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= 1'b0;
			mod_q <= '0;
			pub_q <= '0;
			p_q <= '0;
			q_q <= '0;
			ep_q <= '0;
			eq_q <= '0;
			coef_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DECRYPT_MODE: dec_q <= cfg_data[0];
				REG_MODULUS:      mod_q <= cfg_data;
				REG_PUB_EXP:      pub_q <= cfg_data;
				REG_PRIME_P:      p_q <= cfg_data;
				REG_PRIME_Q:      q_q <= cfg_data;
				REG_EXP_P:        ep_q <= cfg_data;
				REG_EXP_Q:        eq_q <= cfg_data;
				REG_CRT_COEFF:    coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
			tl_q <= 1'b0;
			pass_q <= 1'b0;
			cnt_q <= '0;
			red_sel_q <= '0;
		end else begin
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						pass_q <= 1'b0;
						st_q <= (message > mod_q) ? S_DONE : S_POW_SET;
					end
				end
				S_POW_SET: begin
					cnt_q <= 7'(W);
					red_sel_q <= 2'd0;
					st_q <= S_RED;
				end
				S_RED: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						cnt_q <= 7'(W);
						unique case (red_sel_q)
							2'd0: st_q <= (m_q == '0) ? S_POW_END : S_SQ;
							2'd1: st_q <= S_RED_C;
							default: st_q <= S_DIFF;
						endcase
						if (red_sel_q == 2'd1) red_sel_q <= 2'd2;
					end
				end
				S_SQ:    st_q <= S_SQ_W;
				S_SQ_W:  if (mm_rsp.done) st_q <= e_q[W-1] ? S_MUL : S_POW_END;
				S_MUL:   st_q <= S_MUL_W;
				S_MUL_W: if (mm_rsp.done) st_q <= S_POW_END;
				S_POW_END: begin
					if (m_q != '0 && cnt_q != 7'd1) begin
						cnt_q <= cnt_q - 7'd1;
						st_q <= S_SQ;
					end else if (!dec_q) begin
						st_q <= S_DONE;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
						st_q <= S_POW_SET;
					end else if (p_q == '0) begin
						cnt_q <= 7'(W);
						st_q <= S_RECOMB;
					end else begin
						cnt_q <= 7'(W);
						red_sel_q <= 2'd1;
						st_q <= S_RED_B;
					end
				end
				S_RED_B: st_q <= S_RED;
				S_RED_C: begin
					cnt_q <= 7'(W);
					st_q <= S_RED;
				end
				S_DIFF:  st_q <= S_H;
				S_H:     st_q <= S_H_W;
				S_H_W: begin
					if (mm_rsp.done) begin
						cnt_q <= 7'(W);
						st_q <= S_RECOMB;
					end
				end
				S_RECOMB: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) st_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || out_ready) begin
						ov_q <= 1'b1;
						tl_q <= (msg_q > mod_q);
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (in_valid) msg_q <= message;
			S_POW_SET: begin
				m_q <= !dec_q ? mod_q : (pass_q ? q_q : p_q);
				e_q <= !dec_q ? pub_q : (pass_q ? eq_q : ep_q);
				rem_q <= '0;
				rsh_q <= msg_q;
			end
			S_RED: begin
				rem_q <= rdbl_red[W-1:0];
				rsh_q <= {rsh_q[W-2:0], 1'b0};
				if (cnt_q == 7'd1) begin
					unique case (red_sel_q)
						2'd0: begin
							base_q <= rdbl_red[W-1:0];
							// 1 mod m
							acc_q <= (m_q == W'(1)) ? '0 : W'(1);
						end
						2'd1: t_q <= rdbl_red[W-1:0];
						default: m1_q <= rdbl_red[W-1:0];
					endcase
				end
			end
			S_SQ_W: if (mm_rsp.done) acc_q <= mm_rsp.prod;
			S_MUL_W: if (mm_rsp.done) acc_q <= mm_rsp.prod;
			S_POW_END: begin
				e_q <= {e_q[W-2:0], 1'b0};
				// encrypt result stays in acc_q until the result register takes it
				if (m_q == '0) acc_q <= '0;
				if (!(m_q != '0 && cnt_q != 7'd1)) begin
					if (!dec_q) ;
					else if (!pass_q) m1_q <= (m_q == '0) ? '0 : acc_q;
					else begin
						m2_q <= (m_q == '0) ? '0 : acc_q;
						// next: m1 is already below p; reduce m2 mod p, then coeff mod p
						t_q <= (m_q == '0) ? '0 : acc_q;
						m_q <= p_q;
						acc_q <= '0;
					end
				end
			end
			S_RED_B: begin
				// m1 is already below p; reduce m2 into t_q
				rem_q <= '0;
				rsh_q <= m2_q;
			end
			S_RED_C: begin
				// t_q holds b = m2 mod p; stash in acc_q, reduce coeff
				acc_q <= t_q;
				rem_q <= '0;
				rsh_q <= coef_q;
			end
			S_DIFF: begin
				// m1_q now holds coeff mod p, base_q the real m1
				t_q <= (base_q >= acc_q) ? base_q - acc_q : base_q + (p_q - acc_q);
			end
			S_H_W: begin
				if (mm_rsp.done) begin
					acc_q <= '0;
					rsh_q <= mm_rsp.prod;
				end
			end
			S_RECOMB: begin
				acc_q <= {acc_q[W-2:0], 1'b0} + (rsh_q[W-1] ? q_q : '0);
				rsh_q <= {rsh_q[W-2:0], 1'b0};
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					if (msg_q > mod_q) val_q <= '0;
					else if (dec_q) val_q <= m2_q + acc_q;
					else val_q <= acc_q;
				end
			end
			default: ;
		endcase
		// keep the real m1 available for the difference step
		if (st_q == S_POW_END && dec_q && pass_q && !(m_q != '0 && cnt_q != 7'd1))
			base_q <= m1_q;
	end

endmodule

// File: src/rcm64_modmul.sv
// rcm64_modmul: bit-serial modular multiplier, one multiplier bit per cycle
// depends on rcm64_pkg; operands a, b must already be below m, m nonzero

module rcm64_modmul import rcm64_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	logic [1:0]   st_q;
	logic [6:0]   cnt_q;
	logic         done_q;
	logic [W-1:0] acc_q, a_q, b_q, m_q;
	logic [W:0]   dbl, dbl_red, add, add_red;
	logic [W-1:0] step1;

	// double then conditionally add, each reduced by one compare-subtract
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		step1 = dbl_red[W-1:0];
		add = {1'b0, step1} + {1'b0, a_q};
		add_red = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MM_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				MM_IDLE: begin
					if (req.start) begin
						st_q <= MM_RUN;
						cnt_q <= 7'(W);
					end
				end
				MM_RUN: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= MM_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= MM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == MM_IDLE && req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
		end else if (st_q == MM_RUN) begin
			acc_q <= b_q[W-1] ? add_red[W-1:0] : step1;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign rsp = '{done: done_q, prod: acc_q};

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for rsa_crt_modexp_64, encrypt and crt decrypt
// depends on rcm64_pkg and the rsa_crt_modexp_64 rtl

module tb import rcm64_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [W-1:0] value;
		logic         too_large;
	} rsa_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// block ports, inputs all known from time zero
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DECRYPT_MODE;
	logic [W-1:0]         cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [W-1:0]         message = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [W-1:0]         value;
	logic                 too_large;

	rsa_crt_modexp_64 uut (.*);

	// local copy of the key registers, updated on each accepted write
	logic         key_decrypt;
	logic [W-1:0] key_modulus, key_pub_exp, key_p, key_q, key_dp, key_dq, key_qinv;

	logic [W-1:0] msg_q[$];           // messages waiting for the driver
	rsa_result_t  result_q[$];        // results owed by the block, oldest first
	int           in_gap = 0;
	int           out_gap = 0;
	bit           calm = 1'b0;        // phase without idling on either side
	bit           failed = 1'b0;

	// exact modular product through a 128-bit intermediate
	function automatic logic [W-1:0] mod_mul(logic [W-1:0] a, logic [W-1:0] b,
			logic [W-1:0] m);
		logic [2*W-1:0] prod;
		if (m == '0)
			return '0;
		prod = {64'd0, a} * {64'd0, b};
		return W'(prod % {64'd0, m});
	endfunction

	// left to right square and multiply over all 64 exponent bits
	function automatic logic [W-1:0] mod_pow(logic [W-1:0] base, logic [W-1:0] e,
			logic [W-1:0] m);
		logic [W-1:0] acc, b;
		if (m == '0)
			return '0;
		acc = 64'd1 % m;
		b = base % m;
		for (int i = W - 1; i >= 0; i--) begin
			acc = mod_mul(acc, acc, m);
			if (e[i])
				acc = mod_mul(acc, b, m);
		end
		return acc;
	endfunction

	function automatic rsa_result_t rsa_expected(logic [W-1:0] msg);
		rsa_result_t r;
		logic [W-1:0] m1, m2, a, b, diff, h;
		r.too_large = 1'b0;
		if (msg > key_modulus) begin
			r.value = '0;
			r.too_large = 1'b1;
		end else if (!key_decrypt) begin
			r.value = mod_pow(msg, key_pub_exp, key_modulus);
		end else begin
			m1 = mod_pow(msg, key_dp, key_p);
			m2 = mod_pow(msg, key_dq, key_q);
			h = '0;
			if (key_p != '0) begin
				a = m1 % key_p;
				b = m2 % key_p;
				// a - b + p stays below p when a < b, so plain wrapping is exact
				diff = (a >= b) ? a - b : a - b + key_p;
				h = mod_mul(key_qinv, diff, key_p);
			end
			r.value = m2 + h * key_q;
		end
		return r;
	endfunction

	function automatic logic [W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// driver: hold each item until accepted, then maybe idle, then the next
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			message <= '0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				result_q.push_back(rsa_expected(message));
				busy = 1'b0;
			end
			if (!busy) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (msg_q.size() > 0) begin
					message <= msg_q.pop_front();
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, compare each result item with the oldest owed
	always @(posedge clk or negedge arst_n) begin
		rsa_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected item value=%h too_large=%b",
						$time, value, too_large);
					failed = 1'b1;
				end else begin
					exp_r = result_q.pop_front();
					if (value !== exp_r.value) begin
						$display("%0t: value expected %h actual %h",
							$time, exp_r.value, value);
						failed = 1'b1;
					end
					if (too_large !== exp_r.too_large) begin
						$display("%0t: too_large expected %b actual %b",
							$time, exp_r.too_large, too_large);
						failed = 1'b1;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = pick_gap();
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DECRYPT_MODE: key_decrypt = data[0];
			REG_MODULUS:      key_modulus = data;
			REG_PUB_EXP:      key_pub_exp = data;
			REG_PRIME_P:      key_p = data;
			REG_PRIME_Q:      key_q = data;
			REG_EXP_P:        key_dp = data;
			REG_EXP_Q:        key_dq = data;
			REG_CRT_COEFF:    key_qinv = data;
		endcase
	endtask

	// whole key set; upper bits of the mode data are junk the block must drop
	task automatic load_key(logic dec, logic [W-1:0] n, logic [W-1:0] e,
			logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] dp, logic [W-1:0] dq,
			logic [W-1:0] qinv);
		write_reg(REG_DECRYPT_MODE, {63'(rand64()), dec});
		write_reg(REG_MODULUS, n);
		write_reg(REG_PUB_EXP, e);
		write_reg(REG_PRIME_P, p);
		write_reg(REG_PRIME_Q, q);
		write_reg(REG_EXP_P, dp);
		write_reg(REG_EXP_Q, dq);
		write_reg(REG_CRT_COEFF, qinv);
	endtask

	// edge messages around the modulus, then random ones mostly in range
	task automatic queue_msgs(int count);
		logic [W:0] span;
		msg_q.push_back('0);
		msg_q.push_back(64'd1);
		msg_q.push_back(key_modulus);
		msg_q.push_back(key_modulus + 64'd1);
		msg_q.push_back('1);
		span = {1'b0, key_modulus} + 65'd1;
		repeat (count) begin
			if ($urandom_range(0, 4) == 0)
				msg_q.push_back(rand64());
			else
				msg_q.push_back(W'({1'b0, rand64()} % span));
		end
	endtask

	// block idle: nothing queued, nothing in flight, nothing owed
	task automatic drain();
		while (msg_q.size() > 0 || in_valid || result_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [W-1:0] n;
		key_decrypt = 1'b0;
		{key_modulus, key_pub_exp, key_p, key_q, key_dp, key_dq, key_qinv} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset keys: modulus zero refuses everything but a zero message
		queue_msgs(2);
		drain();

		// textbook key 61 * 53, encrypt without idling, then crt decrypt
		calm = 1'b1;
		load_key(1'b0, 64'd3233, 64'd17, 64'd61, 64'd53, 64'd53, 64'd49, 64'd38);
		queue_msgs(6);
		drain();
		calm = 1'b0;
		write_reg(REG_DECRYPT_MODE, 64'd1);
		queue_msgs(6);
		drain();

		// modulus of one with zero primes in decrypt, then a zero exponent in encrypt
		load_key(1'b1, 64'd1, '0, '0, '0, '0, '0, '0);
		queue_msgs(1);
		drain();
		load_key(1'b0, '1, '0, '1, '1, '0, '1, '1);
		queue_msgs(2);
		drain();

		// all-ones keys but q in both modes
		load_key(1'b0, '1, '1, '1, 64'hffff_ffff_ffff_ffc5, '1, '1, '1);
		queue_msgs(2);
		drain();
		write_reg(REG_DECRYPT_MODE, 64'd1);
		queue_msgs(2);
		drain();

		// random keys, mostly encrypt since it is cheaper
		for (int ph = 0; ph < 4; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			n = rand64();
			load_key(ph % 3 == 2, n, rand64(), rand64() >> $urandom_range(0, 40),
				rand64() >> $urandom_range(0, 40), rand64(), rand64(), rand64());
			queue_msgs(9);
			drain();
		end

		repeat (200) @(posedge clk);
		if (!failed && result_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#(500_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
